// ===== hdl/clock_source_divider_planner_macros.svh =====
// assertion macros for the clock source and divider planner checker
`ifndef CLOCK_SOURCE_DIVIDER_PLANNER_MACROS_SVH
`define CLOCK_SOURCE_DIVIDER_PLANNER_MACROS_SVH

// same-cycle implication under the active-low reset
`define CSPD_ASSERT_IMPLY(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error(msg);

// implication with a fixed delay in cycles
`define CSPD_ASSERT_DELAY(lbl, clk, rst_n, a, n, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> ##n (b)) \
		else $error(msg);

`endif

// ===== hdl/cspd_pkg.sv =====
// package: types, constants and helpers of the clock source and divider planner
`timescale 1ns / 1ps
`default_nettype none

package cspd_pkg;

	// fixed frequencies and limits
	localparam logic [25:0] REF_HZ        = 26'd128000;
	localparam logic [25:0] CPU_MAX_HZ    = 26'd48000000;
	localparam logic [25:0] PERIPH_MAX_HZ = 26'd24000000;
	localparam logic [15:0] TICK_MAX      = 16'hFFFF;

	// divide by 1000 as multiply by ceil(2^36 / 1000), exact below 2^26
	localparam int          TICK_SHIFT = 36;
	localparam logic [26:0] TICK_RECIP = 27'd68719477;

	// configuration register indexes
	localparam logic [2:0] CFG_LOW_XTAL   = 3'd0;
	localparam logic [2:0] CFG_HIGH_XTAL  = 3'd1;
	localparam logic [2:0] CFG_DCO        = 3'd2;
	localparam logic [2:0] CFG_HIGH_OK    = 3'd3;
	localparam logic [2:0] CFG_LOW_OK     = 3'd4;
	localparam logic [2:0] CFG_CPU_LIMIT  = 3'd5;
	localparam logic [2:0] CFG_PERIPH_LIM = 3'd6;

	typedef enum logic [1:0] {
		SRC_REF  = 2'd0,
		SRC_LOW  = 2'd1,
		SRC_DCO  = 2'd2,
		SRC_HIGH = 2'd3
	} src_t;

	typedef struct packed {
		logic        func;
		logic [25:0] requested_freq;
		logic [25:0] present_cpu_freq;
		logic [24:0] present_periph_freq;
	} req_t;

	typedef struct packed {
		logic [1:0]  clock_source;
		logic [2:0]  divide_log2;
		logic [25:0] achieved_freq;
		logic        core_voltage_high;
		logic        voltage_first;
		logic [15:0] tick_reload;
	} result_t;

	typedef struct packed {
		logic [16:0] low_crystal_freq;
		logic [25:0] high_crystal_freq;
		logic [25:0] dco_freq;
		logic        high_crystal_ok;
		logic        low_crystal_ok;
		logic [25:0] low_volt_cpu_limit;
		logic [24:0] low_volt_periph_limit;
	} cfg_t;

	// clamped request entering source selection
	typedef struct packed {
		logic        valid;
		logic        func;
		logic [25:0] freq;
		logic [25:0] pres_cpu;
		logic [24:0] pres_per;
	} sel_in_t;

	// chosen source and divider leaving source selection
	typedef struct packed {
		logic        valid;
		logic        func;
		src_t        source;
		logic [2:0]  k;
		logic [25:0] achieved;
		logic [25:0] pres_cpu;
		logic [24:0] pres_per;
	} sel_out_t;

	// smallest exponent 0..6 with f >= src >> k, else 7
	function automatic logic [2:0] pick_div(input logic [25:0] src, input logic [25:0] f);
		logic [2:0] k;
		k = 3'd7;
		for (int i = 6; i >= 0; i--) begin
			if (f >= (src >> i)) k = 3'(i);
		end
		return k;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/cspd_select.sv =====
// source and divider selection, two register stages
`timescale 1ns / 1ps
`default_nettype none

module cspd_select (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cspd_pkg::cfg_t    cfg,
	input  wire cspd_pkg::sel_in_t sel_in,
	output cspd_pkg::sel_out_t     sel_out
);

	logic [25:0] low_w;
	logic [25:0] hf_min_w;
	logic [25:0] dco_min_w;

	logic        valid_s2;
	logic        func_s2;
	logic [25:0] freq_s2;
	logic [25:0] pres_cpu_s2;
	logic [24:0] pres_per_s2;
	logic        ref_sel_s2;
	logic        low_sel_s2;
	logic        high_ok_s2;
	logic        dco_only_s2;
	logic        hf_only_s2;
	logic [2:0]  k_ref_s2;
	logic [2:0]  k_low_s2;
	logic [2:0]  k_dco_s2;
	logic [2:0]  k_hf_s2;

	logic [25:0] dco_got_w;
	logic [25:0] hf_got_w;
	logic [25:0] dco_diff_w;
	logic [25:0] hf_diff_w;
	logic        dco_wins_w;
	cspd_pkg::src_t source_w;
	logic [2:0]  k_w;
	logic [25:0] achieved_w;

	assign low_w     = {9'd0, cfg.low_crystal_freq};
	assign hf_min_w  = cfg.high_crystal_freq >> 7;
	assign dco_min_w = cfg.dco_freq >> 7;

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= sel_in.valid;
		end
	end

	// stage 2: range flags and divider exponents for every source
	always_ff @(posedge clk) begin
		func_s2     <= sel_in.func;
		freq_s2     <= sel_in.freq;
		pres_cpu_s2 <= sel_in.pres_cpu;
		pres_per_s2 <= sel_in.pres_per;
		ref_sel_s2  <= (sel_in.freq <= cspd_pkg::REF_HZ) && (sel_in.freq >= low_w);
		low_sel_s2  <= (sel_in.freq <= low_w) && cfg.low_crystal_ok;
		high_ok_s2  <= cfg.high_crystal_ok;
		dco_only_s2 <= (sel_in.freq < hf_min_w) && (sel_in.freq >= dco_min_w);
		hf_only_s2  <= (sel_in.freq >= hf_min_w) && (sel_in.freq < dco_min_w);
		k_ref_s2    <= cspd_pkg::pick_div(cspd_pkg::REF_HZ, sel_in.freq);
		k_low_s2    <= cspd_pkg::pick_div(low_w, sel_in.freq);
		k_dco_s2    <= cspd_pkg::pick_div(cfg.dco_freq, sel_in.freq);
		k_hf_s2     <= cspd_pkg::pick_div(cfg.high_crystal_freq, sel_in.freq);
	end

	// closeness of DCO and high crystal, tie goes to the crystal
	assign dco_got_w  = cfg.dco_freq >> k_dco_s2;
	assign hf_got_w   = cfg.high_crystal_freq >> k_hf_s2;
	assign dco_diff_w = (dco_got_w > freq_s2) ? dco_got_w - freq_s2 : freq_s2 - dco_got_w;
	assign hf_diff_w  = (hf_got_w > freq_s2) ? hf_got_w - freq_s2 : freq_s2 - hf_got_w;
	assign dco_wins_w = hf_diff_w > dco_diff_w;

	// source priority
	always_comb begin
		if (ref_sel_s2) begin
			source_w = cspd_pkg::SRC_REF;
		end else if (low_sel_s2) begin
			source_w = cspd_pkg::SRC_LOW;
		end else if (!high_ok_s2 || dco_only_s2) begin
			source_w = cspd_pkg::SRC_DCO;
		end else if (hf_only_s2) begin
			source_w = cspd_pkg::SRC_HIGH;
		end else if (dco_wins_w) begin
			source_w = cspd_pkg::SRC_DCO;
		end else begin
			source_w = cspd_pkg::SRC_HIGH;
		end
	end

	// divider and achieved frequency of the chosen source
	always_comb begin
		unique case (source_w)
			cspd_pkg::SRC_REF: begin
				k_w        = k_ref_s2;
				achieved_w = cspd_pkg::REF_HZ >> k_ref_s2;
			end
			cspd_pkg::SRC_LOW: begin
				k_w        = k_low_s2;
				achieved_w = low_w >> k_low_s2;
			end
			cspd_pkg::SRC_DCO: begin
				k_w        = k_dco_s2;
				achieved_w = dco_got_w;
			end
			cspd_pkg::SRC_HIGH: begin
				k_w        = k_hf_s2;
				achieved_w = hf_got_w;
			end
		endcase
	end

	// stage 3 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_out <= '0;
		end else begin
			sel_out.valid    <= valid_s2;
			sel_out.func     <= func_s2;
			sel_out.source   <= source_w;
			sel_out.k        <= k_w;
			sel_out.achieved <= achieved_w;
			sel_out.pres_cpu <= pres_cpu_s2;
			sel_out.pres_per <= pres_per_s2;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/clock_source_divider_planner.sv =====
// Throughput: one request per cycle; busy stays low, as no unit is shared.
// Four register stages: clamp, range flags and dividers, source choice, voltage and tick.
// The tick reload comes from one 26 by 27 bit reciprocal multiply in the last stage.
// Reset clears the pipeline valids and loads the configuration registers with their defaults.
// Results cannot be stalled; each is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module clock_source_divider_planner (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire cspd_pkg::req_t    request,
	output logic                   result_valid,
	output cspd_pkg::result_t      result,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [25:0]       cfg_data
);

	cspd_pkg::cfg_t     cfg_q;
	cspd_pkg::sel_in_t  sel_in_s1;
	cspd_pkg::sel_out_t sel_out_s3;
	logic               accept_w;
	logic [25:0]        max_w;
	logic [25:0]        clamp_w;
	logic [25:0]        cpu_w;
	logic [25:0]        per_w;
	logic [25:0]        cpu_lim_w;
	logic [25:0]        per_lim_w;
	logic [25:0]        pres_per_w;
	logic [52:0]        prod_w;
	logic [16:0]        quot_w;
	logic [15:0]        tick_w;

	assign busy     = 1'b0;
	assign accept_w = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_crystal_freq      <= 17'd32768;
			cfg_q.high_crystal_freq     <= 26'd48000000;
			cfg_q.dco_freq              <= 26'd3000000;
			cfg_q.high_crystal_ok       <= 1'b1;
			cfg_q.low_crystal_ok        <= 1'b1;
			cfg_q.low_volt_cpu_limit    <= 26'd24000000;
			cfg_q.low_volt_periph_limit <= 25'd12000000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cspd_pkg::CFG_LOW_XTAL:   cfg_q.low_crystal_freq      <= cfg_data[16:0];
				cspd_pkg::CFG_HIGH_XTAL:  cfg_q.high_crystal_freq     <= cfg_data;
				cspd_pkg::CFG_DCO:        cfg_q.dco_freq              <= cfg_data;
				cspd_pkg::CFG_HIGH_OK:    cfg_q.high_crystal_ok       <= cfg_data[0];
				cspd_pkg::CFG_LOW_OK:     cfg_q.low_crystal_ok        <= cfg_data[0];
				cspd_pkg::CFG_CPU_LIMIT:  cfg_q.low_volt_cpu_limit    <= cfg_data;
				cspd_pkg::CFG_PERIPH_LIM: cfg_q.low_volt_periph_limit <= cfg_data[24:0];
				default: ;
			endcase
		end
	end

	// clamp to the maximum of the clock being set
	assign max_w   = request.func ? cspd_pkg::PERIPH_MAX_HZ : cspd_pkg::CPU_MAX_HZ;
	assign clamp_w = (request.requested_freq > max_w) ? max_w : request.requested_freq;

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_in_s1 <= '0;
		end else begin
			sel_in_s1.valid    <= accept_w;
			sel_in_s1.func     <= request.func;
			sel_in_s1.freq     <= clamp_w;
			sel_in_s1.pres_cpu <= request.present_cpu_freq;
			sel_in_s1.pres_per <= request.present_periph_freq;
		end
	end

	cspd_select u_select (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.sel_in  (sel_in_s1),
		.sel_out (sel_out_s3)
	);

	// frequencies after the change, against the low-voltage limits
	assign pres_per_w = {1'b0, sel_out_s3.pres_per};
	assign cpu_w      = sel_out_s3.func ? sel_out_s3.pres_cpu : sel_out_s3.achieved;
	assign per_w      = sel_out_s3.func ? sel_out_s3.achieved : pres_per_w;
	assign cpu_lim_w  = cfg_q.low_volt_cpu_limit;
	assign per_lim_w  = {1'b0, cfg_q.low_volt_periph_limit};

	// tick reload: achieved / 1000 by reciprocal, saturated, zero for peripheral
	assign prod_w = 53'(sel_out_s3.achieved) * 53'(cspd_pkg::TICK_RECIP);
	assign quot_w = prod_w[52:cspd_pkg::TICK_SHIFT];
	always_comb begin
		if (sel_out_s3.func) begin
			tick_w = '0;
		end else if (quot_w > 17'(cspd_pkg::TICK_MAX)) begin
			tick_w = cspd_pkg::TICK_MAX;
		end else begin
			tick_w = quot_w[15:0];
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= sel_out_s3.valid;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		result.clock_source      <= sel_out_s3.source;
		result.divide_log2       <= sel_out_s3.k;
		result.achieved_freq     <= sel_out_s3.achieved;
		result.core_voltage_high <= !((cpu_w <= cpu_lim_w) && (per_w <= per_lim_w));
		result.voltage_first     <= ((cpu_w > cpu_lim_w) && (sel_out_s3.pres_cpu <= cpu_lim_w))
		                         || ((per_w > per_lim_w) && (pres_per_w <= per_lim_w));
		result.tick_reload       <= tick_w;
	end

endmodule

`default_nettype wire

// ===== hdl/cspd_checker.sv =====
// port checker for the clock source and divider planner, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "clock_source_divider_planner_macros.svh"

module cspd_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire cspd_pkg::req_t    request,
	input wire logic              result_valid,
	input wire cspd_pkg::result_t result
);

	// every request is followed by its result
	`CSPD_ASSERT_DELAY(a_req_to_result, clk, arst_n, start && !busy, 4, result_valid, "result missing")

	// no result without an earlier request
	`CSPD_ASSERT_IMPLY(a_result_has_req, clk, arst_n, result_valid, $past(start && !busy, 4), "result without request")

	// a peripheral request carries no tick reload
	`CSPD_ASSERT_IMPLY(a_periph_no_tick, clk, arst_n, result_valid && $past(request.func, 4), result.tick_reload == 16'd0, "tick on peripheral request")

	// raising the voltage first only makes sense when high voltage is needed
	`CSPD_ASSERT_IMPLY(a_first_needs_high, clk, arst_n, result_valid && result.voltage_first, result.core_voltage_high, "voltage first without high voltage")

endmodule

bind clock_source_divider_planner cspd_checker u_cspd_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the clock source and divider planner
`timescale 1ns / 1ps

module testbench;

	localparam int          CLK_HALF      = 2;
	localparam int          CYCLE_LIMIT   = 400000;
	localparam int          DRAIN_CYCLES  = 12;
	localparam logic [31:0] DIVIDE_MAX    = 32'd128;
	localparam logic [31:0] TICKS_PER_SEC = 32'd1000;
	localparam logic [31:0] FREQ_MASK     = 32'h03FF_FFFF;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	cspd_pkg::req_t    request = '0;
	logic              result_valid;
	cspd_pkg::result_t result;
	logic              cfg_we = 1'b0;
	logic [2:0]        cfg_index = cspd_pkg::CFG_LOW_XTAL;
	logic [25:0]       cfg_data = '0;

	// copy of the configuration as the block holds it
	cspd_pkg::cfg_t    clk_cfg;
	cspd_pkg::req_t    queued_requests[$];
	cspd_pkg::result_t planned_results[$];
	logic              req_taken = 1'b0;
	int                mismatch_count = 0;
	int                cycle_count = 0;
	int                burst_left = 1;
	int                gap_left = 0;

	clock_source_divider_planner u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// clock
	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// smallest divider exponent whose quotient does not exceed the frequency
	function automatic logic [2:0] fit_shift(input logic [31:0] src_hz, input logic [31:0] f);
		for (int s = 0; s < 7; s++) begin
			if (f >= (src_hz >> s)) return 3'(s);
		end
		return 3'd7;
	endfunction

	// source, divider, voltage and tick for one request
	function automatic cspd_pkg::result_t plan_clock(input cspd_pkg::req_t rq);
		logic [31:0] f, src_hz, hf_min, dco_min, hf_got, dco_got, hf_err, dco_err;
		logic [31:0] got, cpu, per, tick;
		logic [2:0]  k;
		cspd_pkg::src_t    src;
		cspd_pkg::result_t r;
		f = 32'(rq.requested_freq);
		if (!rq.func && f > 32'(cspd_pkg::CPU_MAX_HZ)) f = 32'(cspd_pkg::CPU_MAX_HZ);
		else if (rq.func && f > 32'(cspd_pkg::PERIPH_MAX_HZ)) f = 32'(cspd_pkg::PERIPH_MAX_HZ);
		if (f <= 32'(cspd_pkg::REF_HZ) && f >= 32'(clk_cfg.low_crystal_freq)) begin
			src = cspd_pkg::SRC_REF;
			src_hz = 32'(cspd_pkg::REF_HZ);
		end else if (f <= 32'(clk_cfg.low_crystal_freq) && clk_cfg.low_crystal_ok) begin
			src = cspd_pkg::SRC_LOW;
			src_hz = 32'(clk_cfg.low_crystal_freq);
		end else if (!clk_cfg.high_crystal_ok) begin
			src = cspd_pkg::SRC_DCO;
			src_hz = 32'(clk_cfg.dco_freq);
		end else begin
			hf_min = 32'(clk_cfg.high_crystal_freq) / DIVIDE_MAX;
			dco_min = 32'(clk_cfg.dco_freq) / DIVIDE_MAX;
			if (f < hf_min && f >= dco_min) begin
				src = cspd_pkg::SRC_DCO;
			end else if (f >= hf_min && f < dco_min) begin
				src = cspd_pkg::SRC_HIGH;
			end else begin
				// both or neither reach the frequency: the dco must come strictly closer to win
				dco_got = 32'(clk_cfg.dco_freq) >> fit_shift(32'(clk_cfg.dco_freq), f);
				hf_got = 32'(clk_cfg.high_crystal_freq)
					>> fit_shift(32'(clk_cfg.high_crystal_freq), f);
				dco_err = (dco_got > f) ? dco_got - f : f - dco_got;
				hf_err = (hf_got > f) ? hf_got - f : f - hf_got;
				src = (hf_err > dco_err) ? cspd_pkg::SRC_DCO : cspd_pkg::SRC_HIGH;
			end
			src_hz = (src == cspd_pkg::SRC_DCO) ? 32'(clk_cfg.dco_freq)
				: 32'(clk_cfg.high_crystal_freq);
		end
		k = fit_shift(src_hz, f);
		got = (src_hz >> k) & FREQ_MASK;
		cpu = rq.func ? 32'(rq.present_cpu_freq) : got;
		per = rq.func ? got : 32'(rq.present_periph_freq);
		tick = rq.func ? 32'd0 : got / TICKS_PER_SEC;
		if (tick > 32'hFFFF) tick = 32'hFFFF;
		r.clock_source = src;
		r.divide_log2 = k;
		r.achieved_freq = got[25:0];
		r.core_voltage_high = !(cpu <= 32'(clk_cfg.low_volt_cpu_limit)
			&& per <= 32'(clk_cfg.low_volt_periph_limit));
		r.voltage_first = (cpu > 32'(clk_cfg.low_volt_cpu_limit)
			&& rq.present_cpu_freq <= clk_cfg.low_volt_cpu_limit)
			|| (per > 32'(clk_cfg.low_volt_periph_limit)
			&& rq.present_periph_freq <= clk_cfg.low_volt_periph_limit);
		r.tick_reload = tick[15:0];
		return r;
	endfunction

	// present frequency: anywhere, at the ends, or hugging the low-voltage limit
	function automatic logic [31:0] pick_present(input logic [31:0] lim, input logic [31:0] top);
		longint v;
		case ($urandom_range(0, 5))
			0: v = 64'sd0;
			1: v = longint'(top);
			2, 3: v = longint'(lim) + longint'($urandom_range(0, 2)) - 64'sd1;
			default: v = longint'($urandom_range(0, top));
		endcase
		if (v < 0) v = 64'sd0;
		if (v > longint'(top)) v = longint'(top);
		return 32'(v);
	endfunction

	// random request, weighted towards divider steps and source boundaries
	function automatic cspd_pkg::req_t make_request();
		cspd_pkg::req_t rq;
		longint f;
		longint base;
		rq.func = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0: f = longint'($urandom & FREQ_MASK);
			1: f = longint'($urandom_range(0, 48000000));
			2, 3: f = longint'(($urandom >> $urandom_range(6, 31)) & FREQ_MASK);
			4, 5, 6: begin
				case ($urandom_range(0, 3))
					0: base = longint'(clk_cfg.high_crystal_freq);
					1: base = longint'(clk_cfg.dco_freq);
					2: base = longint'(clk_cfg.low_crystal_freq);
					default: base = longint'(cspd_pkg::REF_HZ);
				endcase
				f = (base >> $urandom_range(0, 7)) + longint'($urandom_range(0, 2)) - 64'sd1;
			end
			7: f = ($urandom_range(0, 1) ? longint'(cspd_pkg::REF_HZ)
				: longint'(clk_cfg.low_crystal_freq))
				+ longint'($urandom_range(0, 4)) - 64'sd2;
			8: f = longint'($urandom_range(0, 200000));
			default: f = longint'($urandom_range(0, 24000000));
		endcase
		if (f < 0) f = 64'sd0;
		if (f > longint'(FREQ_MASK)) f = longint'(FREQ_MASK);
		rq.requested_freq = 26'(f);
		rq.present_cpu_freq = 26'(pick_present(32'(clk_cfg.low_volt_cpu_limit), 32'd48000000));
		rq.present_periph_freq =
			25'(pick_present(32'(clk_cfg.low_volt_periph_limit), 32'd24000000));
		return rq;
	endfunction

	// one register write at the next falling edge
	task automatic put_reg(input logic [2:0] idx, input logic [25:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	// full register set, written while the block is idle
	task automatic load_config(input cspd_pkg::cfg_t c);
		put_reg(cspd_pkg::CFG_LOW_XTAL, 26'(c.low_crystal_freq));
		put_reg(cspd_pkg::CFG_HIGH_XTAL, c.high_crystal_freq);
		put_reg(cspd_pkg::CFG_DCO, c.dco_freq);
		put_reg(cspd_pkg::CFG_HIGH_OK, 26'(c.high_crystal_ok));
		put_reg(cspd_pkg::CFG_LOW_OK, 26'(c.low_crystal_ok));
		put_reg(cspd_pkg::CFG_CPU_LIMIT, c.low_volt_cpu_limit);
		put_reg(cspd_pkg::CFG_PERIPH_LIM, 26'(c.low_volt_periph_limit));
		@(negedge clk);
		cfg_we <= 1'b0;
		clk_cfg = c;
	endtask

	task automatic add_request(input logic fn, input logic [25:0] f,
			input logic [25:0] pc, input logic [24:0] pp);
		cspd_pkg::req_t rq;
		rq.func = fn;
		rq.requested_freq = f;
		rq.present_cpu_freq = pc;
		rq.present_periph_freq = pp;
		queued_requests.push_back(rq);
	endtask

	// hold until every request is in and every result is back, then let the pipe drain
	task automatic wait_idle();
		while (queued_requests.size() != 0 || start || planned_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_random(input int n);
		repeat (n) queued_requests.push_back(make_request());
		wait_idle();
	endtask

	// request driver: bursts of random length with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !req_taken) begin
			start <= 1'b1;
		end else if (gap_left != 0) begin
			gap_left--;
			start <= 1'b0;
		end else if (queued_requests.size() != 0) begin
			request <= queued_requests.pop_front();
			start <= 1'b1;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = ($urandom_range(0, 7) == 0) ? 100 : int'($urandom_range(1, 24));
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
			end
		end else begin
			start <= 1'b0;
		end
	end

	// result monitor and request capture
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			if (result_valid) begin
				if (planned_results.size() == 0) begin
					$display("%0t: result with none outstanding: %p", $time, result);
					mismatch_count++;
				end else begin
					cspd_pkg::result_t want;
					want = planned_results.pop_front();
					if (result.clock_source !== want.clock_source) begin
						$display("%0t: clock_source expected %0d got %0d", $time,
							want.clock_source, result.clock_source);
						mismatch_count++;
					end
					if (result.divide_log2 !== want.divide_log2) begin
						$display("%0t: divide_log2 expected %0d got %0d", $time,
							want.divide_log2, result.divide_log2);
						mismatch_count++;
					end
					if (result.achieved_freq !== want.achieved_freq) begin
						$display("%0t: achieved_freq expected %0d got %0d", $time,
							want.achieved_freq, result.achieved_freq);
						mismatch_count++;
					end
					if (result.core_voltage_high !== want.core_voltage_high) begin
						$display("%0t: core_voltage_high expected %0b got %0b", $time,
							want.core_voltage_high, result.core_voltage_high);
						mismatch_count++;
					end
					if (result.voltage_first !== want.voltage_first) begin
						$display("%0t: voltage_first expected %0b got %0b", $time,
							want.voltage_first, result.voltage_first);
						mismatch_count++;
					end
					if (result.tick_reload !== want.tick_reload) begin
						$display("%0t: tick_reload expected %0d got %0d", $time,
							want.tick_reload, result.tick_reload);
						mismatch_count++;
					end
				end
			end
			req_taken <= start && !busy;
			if (start && !busy) planned_results.push_back(plan_clock(request));
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		cspd_pkg::cfg_t c;
		clk_cfg.low_crystal_freq = 17'd32768;
		clk_cfg.high_crystal_freq = 26'd48000000;
		clk_cfg.dco_freq = 26'd3000000;
		clk_cfg.high_crystal_ok = 1'b1;
		clk_cfg.low_crystal_ok = 1'b1;
		clk_cfg.low_volt_cpu_limit = 26'd24000000;
		clk_cfg.low_volt_periph_limit = 25'd12000000;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset configuration: zero and saturated requests, source boundaries, tie, voltage
		add_request(1'b0, 26'd0, 26'd0, 25'd0);
		add_request(1'b1, 26'd0, 26'd0, 25'd0);
		add_request(1'b0, 26'h3FFFFFF, 26'd0, 25'd0);
		add_request(1'b1, 26'h3FFFFFF, 26'd48000000, 25'd24000000);
		add_request(1'b0, 26'd48000000, 26'd24000000, 25'd12000000);
		add_request(1'b1, 26'd24000000, 26'd48000000, 25'd0);
		add_request(1'b0, 26'd128000, 26'd1000000, 25'd1000000);
		add_request(1'b0, 26'd32768, 26'd1000000, 25'd1000000);
		add_request(1'b0, 26'd32767, 26'd1000000, 25'd1000000);
		add_request(1'b0, 26'd128001, 26'd1000000, 25'd1000000);
		add_request(1'b0, 26'd3000000, 26'd1000000, 25'd1000000);
		add_request(1'b0, 26'd375000, 26'd1000000, 25'd1000000);
		add_request(1'b0, 26'd374999, 26'd1000000, 25'd1000000);
		add_request(1'b0, 26'd23437, 26'd1000000, 25'd1000000);
		add_request(1'b1, 26'd12000000, 26'd24000000, 25'd12000000);
		add_request(1'b1, 26'd12000001, 26'd24000000, 25'd12000000);
		add_request(1'b0, 26'd24000000, 26'd24000000, 25'd0);
		add_request(1'b0, 26'd30000000, 26'd0, 25'd12000001);
		add_request(1'b1, 26'd5000000, 26'd24000001, 25'd0);
		add_request(1'b0, 26'd1000, 26'd48000000, 25'd24000000);
		add_request(1'b0, 26'd1500000, 26'd48000000, 25'd24000000);
		add_request(1'b1, 26'd100000, 26'd24000001, 25'd12000001);
		wait_idle();

		// every register at its top
		c.low_crystal_freq = 17'd100000;
		c.high_crystal_freq = 26'd48000000;
		c.dco_freq = 26'd48000000;
		c.high_crystal_ok = 1'b1;
		c.low_crystal_ok = 1'b1;
		c.low_volt_cpu_limit = 26'd48000000;
		c.low_volt_periph_limit = 25'd24000000;
		load_config(c);
		run_random(80);

		// every register at its bottom, both crystals failed
		c.low_crystal_freq = 17'd1;
		c.high_crystal_freq = 26'd1;
		c.dco_freq = 26'd1;
		c.high_crystal_ok = 1'b0;
		c.low_crystal_ok = 1'b0;
		c.low_volt_cpu_limit = 26'd0;
		c.low_volt_periph_limit = 25'd0;
		load_config(c);
		run_random(80);

		// usual frequencies with one crystal down at a time
		c.low_crystal_freq = 17'd32768;
		c.high_crystal_freq = 26'd48000000;
		c.dco_freq = 26'd3000000;
		c.high_crystal_ok = 1'b0;
		c.low_crystal_ok = 1'b1;
		c.low_volt_cpu_limit = 26'd24000000;
		c.low_volt_periph_limit = 25'd12000000;
		load_config(c);
		run_random(60);
		c.high_crystal_ok = 1'b1;
		c.low_crystal_ok = 1'b0;
		load_config(c);
		run_random(60);

		// random settings
		repeat (10) begin
			case ($urandom_range(0, 3))
				0: c.low_crystal_freq = 17'd32768;
				1: c.low_crystal_freq = 17'd1;
				2: c.low_crystal_freq = 17'd100000;
				default: c.low_crystal_freq = 17'($urandom_range(1, 100000));
			endcase
			case ($urandom_range(0, 2))
				0: c.high_crystal_freq = 26'(48000000 >> $urandom_range(0, 3));
				default: c.high_crystal_freq = 26'($urandom_range(1, 48000000));
			endcase
			case ($urandom_range(0, 2))
				0: c.dco_freq = 26'(48000000 >> $urandom_range(0, 5));
				default: c.dco_freq = 26'($urandom_range(1, 48000000));
			endcase
			c.high_crystal_ok = ($urandom_range(0, 3) != 0);
			c.low_crystal_ok = ($urandom_range(0, 3) != 0);
			c.low_volt_cpu_limit = $urandom_range(0, 1)
				? 26'd24000000 : 26'($urandom_range(0, 48000000));
			c.low_volt_periph_limit = $urandom_range(0, 1)
				? 25'd12000000 : 25'($urandom_range(0, 24000000));
			load_config(c);
			run_random(115);
		end

		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
